FILE: hdl/rfid_uid64_to_uid40_text_core_defines.svh
// assertion macros used by the back end of the rfid uid extraction core
`ifndef RFID_UID64_TO_UID40_TEXT_CORE_DEFINES_SVH
`define RFID_UID64_TO_UID40_TEXT_CORE_DEFINES_SVH

// property checked on every clock edge outside reset
`define RFIDUID_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked on every clock edge, reset included
`define RFIDUID_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/rfiduid_pkg.sv
// types, constants and helper functions of the rfid uid extraction core
`default_nettype none

package rfiduid_pkg;

  localparam int unsigned FrameDigits = 16;
  localparam int unsigned FrameWidth  = 64;
  localparam int unsigned IdRows      = 10;
  localparam int unsigned IdFirstBit  = 9;
  localparam int unsigned RowBits     = 5;
  localparam int unsigned IdWidth     = 40;
  localparam int unsigned HexDigits   = 10;
  localparam int unsigned DecDigits   = 13;
  localparam int unsigned BcdWidth    = 4 * DecDigits;
  localparam int unsigned CountWidth  = 5;
  localparam int unsigned RemWidth    = 4;
  localparam int unsigned StepWidth   = 6;

  localparam logic [CountWidth-1:0] CountMax  = '1;
  localparam logic [CountWidth-1:0] CountGood = CountWidth'(FrameDigits);

  // index 0 is the rightmost character
  localparam logic [15:0][7:0] HexTable = "FEDCBA9876543210";

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
    logic       out_error;
  } out_res_t;

  typedef struct packed {
    logic               error;
    logic               dec_fmt;
    logic [IdWidth-1:0] id;
  } job_t;

  typedef enum logic [1:0] {
    BackIdle,
    BackConv,
    BackEmit
  } back_state_e;

  // bit 4 set flags a character that is not a hex digit
  function automatic logic [4:0] digit_decode(input logic [7:0] c);
    logic [4:0] d;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = {1'b0, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = {1'b0, 4'(c - 8'h57)};
    end else begin
      d = 5'h10;
    end
    return d;
  endfunction

  // four data bits of each row, row 0 lands in the top nibble
  function automatic logic [IdWidth-1:0] extract_id(input logic [FrameWidth-1:0] f);
    logic [IdWidth-1:0] id;
    for (int r = 0; r < IdRows; r++) begin
      id[4*(IdRows-1-r) +: 4] = f[(FrameWidth - 4 - IdFirstBit - RowBits*r) +: 4];
    end
    return id;
  endfunction

  // add three to every bcd digit of five or more
  function automatic logic [BcdWidth-1:0] bcd_adjust(input logic [BcdWidth-1:0] b);
    logic [BcdWidth-1:0] o;
    for (int i = 0; i < DecDigits; i++) begin
      o[4*i +: 4] = (b[4*i +: 4] >= 4'd5) ? b[4*i +: 4] + 4'd3 : b[4*i +: 4];
    end
    return o;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/rfiduid_front.sv
// front end: config register, character decode, frame accumulation and job build
`default_nettype none

module rfiduid_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic                 cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire rfiduid_pkg::in_req_t in_data_i,
  output logic                      job_valid_o,
  input  wire logic                 job_ready_i,
  output rfiduid_pkg::job_t         job_o
);
  import rfiduid_pkg::*;

  logic                  fmt_q;
  logic [FrameWidth-1:0] acc_q, acc_d;
  logic [CountWidth-1:0] cnt_q, cnt_d;
  logic                  bad_q, bad_d;
  logic [4:0]            digit;
  logic                  accept;

  // only the last character needs room in the queue
  assign in_ready_o  = !in_data_i.in_last || job_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign job_valid_o = in_valid_i && in_data_i.in_last;

  always_comb begin
    digit = digit_decode(in_data_i.in_char);
    acc_d = {acc_q[FrameWidth-5:0], (digit[4] ? 4'h0 : digit[3:0])};
    cnt_d = (cnt_q == CountMax) ? cnt_q : cnt_q + 1'b1;
    bad_d = bad_q || digit[4];
  end

  assign job_o.error   = bad_d || (cnt_d != CountGood);
  assign job_o.dec_fmt = fmt_q;
  assign job_o.id      = extract_id(acc_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= 1'b0;
    end else if (cfg_we_i) begin
      fmt_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
      bad_q <= 1'b0;
    end else if (accept) begin
      if (in_data_i.in_last) begin
        acc_q <= '0;
        cnt_q <= '0;
        bad_q <= 1'b0;
      end else begin
        acc_q <= acc_d;
        cnt_q <= cnt_d;
        bad_q <= bad_d;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rfiduid_fifo.sv
// small job queue between front end and back end
`default_nettype none

module rfiduid_fifo #(
  parameter int unsigned Depth = 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_valid_i,
  output logic                   push_ready_o,
  input  wire rfiduid_pkg::job_t push_data_i,
  output logic                   pop_valid_o,
  input  wire logic              pop_ready_i,
  output rfiduid_pkg::job_t      pop_data_o
);
  import rfiduid_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rfiduid_back.sv
// back end: binary to bcd conversion and digit emission into the output register
`default_nettype none

`include "rfid_uid64_to_uid40_text_core_defines.svh"

module rfiduid_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              job_valid_i,
  output logic                   job_ready_o,
  input  wire rfiduid_pkg::job_t job_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output rfiduid_pkg::out_res_t  out_data_o
);
  import rfiduid_pkg::*;

  back_state_e          state_q, state_d;
  logic [RemWidth-1:0]  rem_q, rem_d;
  logic [StepWidth-1:0] step_q, step_d;
  logic [BcdWidth-1:0]  digs_q, digs_d;
  logic [IdWidth-1:0]   bin_q, bin_d;
  logic                 err_q, err_d;
  logic                 out_valid_q, out_valid_d;
  out_res_t             out_q, out_d;
  logic [BcdWidth-1:0]  adj;
  logic                 slot_free;
  logic                 load_out;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    step_d      = step_q;
    digs_d      = digs_q;
    bin_d       = bin_q;
    err_d       = err_q;
    job_ready_o = 1'b0;
    load_out    = 1'b0;
    adj         = bcd_adjust(digs_q);

    unique case (state_q)
      BackIdle: begin
        job_ready_o = 1'b1;
        if (job_valid_i) begin
          err_d = job_i.error;
          if (job_i.error) begin
            rem_d   = RemWidth'(1);
            state_d = BackEmit;
          end else if (job_i.dec_fmt) begin
            bin_d   = job_i.id;
            digs_d  = '0;
            step_d  = StepWidth'(IdWidth);
            state_d = BackConv;
          end else begin
            digs_d  = {job_i.id, {(BcdWidth - IdWidth){1'b0}}};
            rem_d   = RemWidth'(HexDigits);
            state_d = BackEmit;
          end
        end
      end
      // double dabble, one binary bit per cycle
      BackConv: begin
        digs_d = {adj[BcdWidth-2:0], bin_q[IdWidth-1]};
        bin_d  = {bin_q[IdWidth-2:0], 1'b0};
        step_d = step_q - 1'b1;
        if (step_q == StepWidth'(1)) begin
          rem_d   = RemWidth'(DecDigits);
          state_d = BackEmit;
        end
      end
      BackEmit: begin
        if (slot_free) begin
          load_out = 1'b1;
          digs_d   = {digs_q[BcdWidth-5:0], 4'h0};
          rem_d    = rem_q - 1'b1;
          if (rem_q == RemWidth'(1)) begin
            state_d = BackIdle;
          end
        end
      end
      default: begin
        state_d = BackIdle;
      end
    endcase

    out_d.out_char  = err_q ? 8'h00 : HexTable[digs_q[BcdWidth-1 -: 4]];
    out_d.out_last  = (rem_q == RemWidth'(1));
    out_d.out_error = err_q;

    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BackIdle;
      rem_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rem_q       <= rem_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digs_q <= digs_d;
    bin_q  <= bin_d;
    err_q  <= err_d;
    if (load_out) begin
      out_q <= out_d;
    end
  end

  `RFIDUID_ASSERT(a_err_is_last, clk_i, rst_ni,
                  out_valid_q && out_q.out_error |-> out_q.out_last,
                  "error result not marked last")
  `RFIDUID_ASSERT(a_emit_rem, clk_i, rst_ni,
                  state_q == BackEmit |-> rem_q != '0,
                  "emit state with no digits left")
  `RFIDUID_ASSERT(a_conv_done, clk_i, rst_ni,
                  state_q == BackConv && step_q == StepWidth'(1) |=>
                  state_q == BackEmit && rem_q == RemWidth'(DecDigits),
                  "conversion did not hand over to emission")
  // once reset has been seen low, the back end must be idle with no valid output
  `RFIDUID_ASSERT_ALWAYS(a_reset_quiet, clk_i,
                         !rst_ni |=> !out_valid_q && state_q == BackIdle,
                         "back end active during reset")

endmodule

`default_nettype wire

FILE: hdl/rfid_uid64_to_uid40_text_core.sv
// one character request per cycle; the front end never stalls unless the job queue is full
// hex frame or error: job goes through queue and back end state into the output register
// decimal frame: double dabble over 40 id bits, then 13 results; results one per cycle if taken
// back end holds one frame at a time, from idle to emission; the queue absorbs the rest
// reset clears accumulator, count, flags, queue and output valid; format resets to hex
`default_nettype none

module rfid_uid64_to_uid40_text_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire rfiduid_pkg::in_req_t  in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output rfiduid_pkg::out_res_t      out_data_o
);
  import rfiduid_pkg::*;

  logic push_valid, push_ready;
  logic pop_valid, pop_ready;
  job_t push_job, pop_job;

  rfiduid_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .job_valid_o (push_valid),
    .job_ready_i (push_ready),
    .job_o       (push_job)
  );

  rfiduid_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_job)
  );

  rfiduid_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (pop_valid),
    .job_ready_o (pop_ready),
    .job_i       (pop_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
